// File: src/rkxy_pkg.sv
package rkxy_pkg;

  // word format and field widths
  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = 16;
  localparam int H_W        = 31;
  localparam int MTH_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int KIDX_W     = 2;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int RND_W      = PROD_W - FRAC_W;

  // divide by six as multiply by reciprocal, then shift
  localparam int                DIV_SHIFT = 34;
  localparam logic [WORD_W-1:0] RECIP6    = 32'hAAAA_AAAB;

  // saturation limits
  localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  // register reset values
  localparam logic [MTH_W-1:0]  METHOD_RST = 2'd2;
  localparam logic [H_W-1:0]    STEP_RST   = 31'd13107;
  localparam logic [WORD_W-1:0] END_RST    = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_METHOD = 2'd0,
    REG_STEP   = 2'd1,
    REG_END    = 2'd2
  } cfg_reg_t;

  typedef enum logic [MTH_W-1:0] {
    MTH_EULER = 2'd0,
    MTH_HEUN  = 2'd1,
    MTH_RK4   = 2'd2
  } method_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM1,
    S_SUM2,
    S_MUL,
    S_RND,
    S_ACC,
    S_DMAG,
    S_DMUL,
    S_UPD
  } state_t;

  typedef enum logic [1:0] {
    KT_ZERO,
    KT_HALF,
    KT_FULL
  } kterm_t;

  typedef enum logic [1:0] {
    XS_X,
    XS_MID,
    XS_FULL
  } xsel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_DBL,
    ACC_ADD
  } acc_op_t;

  typedef enum logic {
    MUL_STEP,
    MUL_RECIP
  } mul_sel_t;

  typedef enum logic [1:0] {
    YS_FULL,
    YS_HALF,
    YS_DIV
  } ysel_t;

  // controller to datapath
  typedef struct packed {
    logic     accept;
    logic     ld_xmid;
    logic     ld_t;
    kterm_t   kterm;
    logic     ld_mag;
    logic     mag_acc;
    xsel_t    xsel;
    logic     ld_prod;
    mul_sel_t mul_sel;
    logic     ld_k;
    acc_op_t  acc_op;
    logic     upd;
    ysel_t    ysel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic    out_free;
    logic    step_go;
    method_t method;
  } dp_stat_t;

  // saturating signed add
  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      sat_add = s[WORD_W] ? WMIN : WMAX;
    end else begin
      sat_add = s[WORD_W-1:0];
    end
  endfunction

  // saturating doubling, same as sat_add(a, a)
  function automatic logic [WORD_W-1:0] sat_dbl(input logic [WORD_W-1:0] a);
    if (a[WORD_W-1] != a[WORD_W-2]) begin
      sat_dbl = a[WORD_W-1] ? WMIN : WMAX;
    end else begin
      sat_dbl = {a[WORD_W-2:0], 1'b0};
    end
  endfunction

  // halve rounding toward minus infinity
  function automatic logic [WORD_W-1:0] half_floor(input logic [WORD_W-1:0] a);
    half_floor = {a[WORD_W-1], a[WORD_W-1:1]};
  endfunction

endpackage

// File: src/rkxy_in_if.sv
interface rkxy_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [rkxy_pkg::WORD_W-1:0]  start_x;
  logic signed [rkxy_pkg::WORD_W-1:0]  start_y;

  modport source (output valid, command, start_x, start_y, input ready);
  modport sink   (input valid, command, start_x, start_y, output ready);
endinterface

// File: src/rkxy_out_if.sv
interface rkxy_out_if;
  logic                                valid;
  logic                                ready;
  logic [rkxy_pkg::STEP_W-1:0]         step_index;
  logic signed [rkxy_pkg::WORD_W-1:0]  x_value;
  logic signed [rkxy_pkg::WORD_W-1:0]  y_value;
  logic signed [rkxy_pkg::WORD_W-1:0]  slope;
  logic                                done_res;

  modport source (output valid, step_index, x_value, y_value, slope, done_res, input ready);
  modport sink   (input valid, step_index, x_value, y_value, slope, done_res, output ready);
endinterface

// File: src/rkxy_ctrl.sv
module rkxy_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rkxy_pkg::dp_stat_t stat,
  output rkxy_pkg::dp_cmd_t  cmd
);
  import rkxy_pkg::*;

  state_t            state_r, state_nxt;
  logic [KIDX_W-1:0] kidx_r, kidx_nxt;
  logic              accept;
  logic              last_k;

  // handshake on the input side
  assign in_ready = (state_r == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  // final slope evaluation of the selected method
  always_comb begin
    case (stat.method)
      MTH_EULER: last_k = (kidx_r == 2'd0);
      MTH_HEUN:  last_k = (kidx_r == 2'd1);
      default:   last_k = (kidx_r == 2'd3);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    kidx_nxt  = kidx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && stat.step_go) begin
          state_nxt = S_SUM1;
          kidx_nxt  = '0;
        end
      end
      S_SUM1: state_nxt = S_SUM2;
      S_SUM2: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_RND;
      S_RND: begin
        if (last_k) begin
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_SUM1;
          kidx_nxt  = kidx_r + 2'd1;
        end
      end
      S_ACC:  state_nxt = (stat.method == MTH_EULER || stat.method == MTH_HEUN) ? S_UPD : S_DMAG;
      S_DMAG: state_nxt = S_DMUL;
      S_DMUL: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.kterm   = KT_ZERO;
    cmd.xsel    = XS_X;
    cmd.mul_sel = MUL_STEP;
    cmd.acc_op  = ACC_HOLD;
    cmd.ysel    = YS_FULL;
    unique case (state_r)
      S_IDLE: cmd.accept = accept;
      S_SUM1: begin
        cmd.ld_t    = 1'b1;
        cmd.ld_xmid = (kidx_r == 2'd0);
        if (kidx_r == 2'd0) begin
          cmd.kterm = KT_ZERO;
        end else if (stat.method == MTH_HEUN || kidx_r == 2'd3) begin
          cmd.kterm = KT_FULL;
        end else begin
          cmd.kterm = KT_HALF;
        end
        // fold the previous slope into the running sum
        if (kidx_r == 2'd1) begin
          cmd.acc_op = ACC_LOAD;
        end else if (kidx_r != 2'd0) begin
          cmd.acc_op = ACC_DBL;
        end
      end
      S_SUM2: begin
        cmd.ld_mag = 1'b1;
        if (kidx_r == 2'd0) begin
          cmd.xsel = XS_X;
        end else if (stat.method == MTH_HEUN || kidx_r == 2'd3) begin
          cmd.xsel = XS_FULL;
        end else begin
          cmd.xsel = XS_MID;
        end
      end
      S_MUL: cmd.ld_prod = 1'b1;
      S_RND: cmd.ld_k = 1'b1;
      S_ACC: cmd.acc_op = (stat.method == MTH_EULER) ? ACC_LOAD : ACC_ADD;
      S_DMAG: begin
        cmd.ld_mag  = 1'b1;
        cmd.mag_acc = 1'b1;
      end
      S_DMUL: begin
        cmd.ld_prod = 1'b1;
        cmd.mul_sel = MUL_RECIP;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        case (stat.method)
          MTH_EULER: cmd.ysel = YS_FULL;
          MTH_HEUN:  cmd.ysel = YS_HALF;
          default:   cmd.ysel = YS_DIV;
        endcase
      end
      default: cmd.accept = 1'b0;
    endcase
  end

  // slope evaluations follow one another in order
  a_kidx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND && !last_k) |=>
      (state_r == S_SUM1 && kidx_r == $past(kidx_r) + 2'd1))
    else $error("slope index did not advance");

  // a load or a finished stepping leaves the block idle
  a_no_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !stat.step_go) |=> state_r == S_IDLE)
    else $error("controller left idle without a step");

  // the divide only follows the final accumulation
  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && state_r == S_DMAG) |-> $past(state_r) == S_ACC)
    else $error("divide started out of order");

endmodule

// File: src/rkxy_dp.sv
module rkxy_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rkxy_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rkxy_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_command,
  input  logic signed [rkxy_pkg::WORD_W-1:0] in_start_x,
  input  logic signed [rkxy_pkg::WORD_W-1:0] in_start_y,
  rkxy_out_if.source                        out_ch,
  input  rkxy_pkg::dp_cmd_t                 cmd,
  output rkxy_pkg::dp_stat_t                stat
);
  import rkxy_pkg::*;

  // configuration
  logic [MTH_W-1:0]         method_r;
  logic [H_W-1:0]           h_r;
  logic signed [WORD_W-1:0] end_x_r;

  // integration state
  logic signed [WORD_W-1:0] x_r;
  logic signed [WORD_W-1:0] y_r;
  logic [STEP_W-1:0]        cnt_r;

  // working registers
  logic [WORD_W-1:0] xm_r, xh_r, t_r, k_r, acc_r, mag_r;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;

  // report registers
  logic                     out_valid_r;
  logic [STEP_W-1:0]        out_idx_r;
  logic signed [WORD_W-1:0] out_x_r, out_y_r, out_slope_r;
  logic                     out_done_r;

  logic                     is_load;
  logic                     below_end;
  logic signed [WORD_W-1:0] rep_x, rep_y;
  logic [STEP_W-1:0]        rep_cnt;
  logic [WORD_W-1:0]        h_w, h_half;
  logic [WORD_W-1:0]        kterm_v, xsel_v, sum_v, mag_src, mul_a;
  logic [PROD_W-1:0]        prod_nxt, rnd_sum;
  logic [RND_W-1:0]         rnd_q, rnd_lim;
  logic [WORD_W-1:0]        sat_mag, k_nxt, q_mag, q_v, ysel_v;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= METHOD_RST;
      h_r      <= STEP_RST;
      end_x_r  <= END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_METHOD: method_r <= cfg_wdata[MTH_W-1:0];
        REG_STEP:   h_r      <= cfg_wdata[H_W-1:0];
        REG_END:    end_x_r  <= cfg_wdata[WORD_W-1:0];
        default:    method_r <= method_r;
      endcase
    end
  end

  // unused selector code runs classical fourth order
  assign stat.method = (method_r == MTH_EULER) ? MTH_EULER :
                       (method_r == MTH_HEUN)  ? MTH_HEUN  : MTH_RK4;

  // report of the point before any step
  assign is_load      = (in_command == CMD_LOAD);
  assign below_end    = (x_r < end_x_r);
  assign rep_x        = is_load ? in_start_x : x_r;
  assign rep_y        = is_load ? in_start_y : y_r;
  assign rep_cnt      = is_load ? '0 : cnt_r;
  assign stat.step_go = !is_load && below_end;
  assign stat.out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_idx_r   <= rep_cnt;
      out_x_r     <= rep_x;
      out_y_r     <= rep_y;
      out_slope_r <= sat_add(rep_x, rep_y);
      out_done_r  <= !is_load && !below_end;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.step_index = out_idx_r;
  assign out_ch.x_value    = out_x_r;
  assign out_ch.y_value    = out_y_r;
  assign out_ch.slope      = out_slope_r;
  assign out_ch.done_res   = out_done_r;

  // step size and half step as words
  assign h_w    = WORD_W'(h_r);
  assign h_half = WORD_W'(h_r >> 1);

  // slope argument: y plus scaled k, then x term
  always_comb begin
    case (cmd.kterm)
      KT_HALF: kterm_v = half_floor(k_r);
      KT_FULL: kterm_v = k_r;
      default: kterm_v = '0;
    endcase
    case (cmd.xsel)
      XS_MID:  xsel_v = xm_r;
      XS_FULL: xsel_v = xh_r;
      default: xsel_v = x_r;
    endcase
  end

  assign sum_v   = sat_add(xsel_v, t_r);
  assign mag_src = cmd.mag_acc ? acc_r : sum_v;

  // shared unsigned multiplier, magnitude times step or reciprocal
  assign mul_a    = (cmd.mul_sel == MUL_RECIP) ? RECIP6 : h_w;
  assign prod_nxt = mul_a * mag_r;

  // round half away from zero, saturate, restore sign
  assign rnd_sum = prod_r + (PROD_W'(1) << (FRAC_W - 1));
  assign rnd_q   = rnd_sum[PROD_W-1:FRAC_W];
  assign rnd_lim = neg_r ? RND_W'(WMIN) : RND_W'(WMAX);
  assign sat_mag = (rnd_q > rnd_lim) ? rnd_lim[WORD_W-1:0] : rnd_q[WORD_W-1:0];
  assign k_nxt   = neg_r ? -sat_mag : sat_mag;

  // quotient by six, truncated toward zero
  assign q_mag = WORD_W'(prod_r[PROD_W-1:DIV_SHIFT]);
  assign q_v   = neg_r ? -q_mag : q_mag;

  always_comb begin
    case (cmd.ysel)
      YS_HALF: ysel_v = half_floor(acc_r);
      YS_DIV:  ysel_v = q_v;
      default: ysel_v = acc_r;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.ld_xmid) begin
      xm_r <= sat_add(x_r, h_half);
      xh_r <= sat_add(x_r, h_w);
    end
    if (cmd.ld_t) begin
      t_r <= sat_add(y_r, kterm_v);
    end
    if (cmd.ld_mag) begin
      mag_r <= mag_src[WORD_W-1] ? -mag_src : mag_src;
      neg_r <= mag_src[WORD_W-1];
    end
    if (cmd.ld_prod) begin
      prod_r <= prod_nxt;
    end
    if (cmd.ld_k) begin
      k_r <= k_nxt;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= k_r;
      ACC_DBL:  acc_r <= sat_add(acc_r, sat_dbl(k_r));
      ACC_ADD:  acc_r <= sat_add(acc_r, k_r);
      default:  acc_r <= acc_r;
    endcase
  end

  // current point and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      y_r   <= '0;
      cnt_r <= '0;
    end else if (cmd.accept && is_load) begin
      x_r   <= in_start_x;
      y_r   <= in_start_y;
      cnt_r <= '0;
    end else if (cmd.upd) begin
      x_r <= xh_r;
      y_r <= sat_add(y_r, ysel_v);
      if (cnt_r != {STEP_W{1'b1}}) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // a report appears only for an accepted word
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(cmd.accept))
    else $error("report without an accepted word");

  // the counter moves only on a load or a finished step
  a_cnt_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |-> ($past(cmd.upd) || $past(cmd.accept)))
    else $error("step counter changed unexpectedly");

  // a waiting report holds steady until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=>
      (out_valid_r && $stable(out_x_r) && $stable(out_y_r)))
    else $error("waiting report changed");

endmodule

// File: src/runge_kutta_stepper_x_plus_y_core.sv
// the report of a word is registered: it is valid in the cycle after the word is accepted
// a step word keeps the block busy, and no new word is taken until the step is applied
// (per slope: sum, multiply, round on the shared multiplier; then sum, and divide for RK4)
// a load word, or a step once x has reached end_x, is handled without leaving idle
// reset (synchronous, rst_n low) clears x, y and the step count, restores register defaults
module runge_kutta_stepper_x_plus_y_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rkxy_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rkxy_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rkxy_in_if.sink                         in_ch,
  rkxy_out_if.source                      out_ch
);
  import rkxy_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  // sequencer
  rkxy_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and state
  rkxy_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_command (in_ch.command),
    .in_start_x (in_ch.start_x),
    .in_start_y (in_ch.start_y),
    .out_ch     (out_ch),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// File: bench/runge_kutta_stepper_x_plus_y_core_tb.sv
module runge_kutta_stepper_x_plus_y_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rkxy_pkg::*;

  localparam int          CLK_PERIOD    = 20;
  localparam int          RST_CYCLES    = 10;
  localparam int          SETTLE_CYCLES = 30;
  localparam int          RX_HOLD_CYC   = 400;
  localparam int unsigned LIMIT_CYCLES  = 500_000;
  localparam int          MAX_SHOWN     = 10;
  localparam int          Q_ONE         = 65536;

  // selector value outside the method list, handled like the fourth order method
  localparam logic [MTH_W-1:0] MTH_SPARE = 2'd3;

  typedef struct packed {
    cmd_t                     command;
    logic signed [WORD_W-1:0] start_x;
    logic signed [WORD_W-1:0] start_y;
  } stim_word_t;

  typedef struct packed {
    logic [STEP_W-1:0]        step_index;
    logic signed [WORD_W-1:0] x_value;
    logic signed [WORD_W-1:0] y_value;
    logic signed [WORD_W-1:0] slope;
    logic                     done_res;
  } report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rkxy_in_if  in_ch ();
  rkxy_out_if out_ch ();

  runge_kutta_stepper_x_plus_y_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor copy of registers and integrator state
  logic [MTH_W-1:0]         rk_method = METHOD_RST;
  logic [H_W-1:0]           rk_h      = STEP_RST;
  logic signed [WORD_W-1:0] rk_end_x  = END_RST;
  logic signed [WORD_W-1:0] pt_x      = '0;
  logic signed [WORD_W-1:0] pt_y      = '0;
  logic [STEP_W-1:0]        pt_steps  = '0;

  stim_word_t cmd_q[$];
  report_t    report_q[$];
  stim_word_t tx_word;
  bit         tx_live     = 1'b0;
  int         tx_gap      = 0;
  int         rx_gap      = 0;
  bit         idle_on     = 1'b1;
  bit         rx_block;
  bit         rx_hold_go  = 1'b0;
  int         fail_cnt    = 0;

  // saturating add at word width
  function automatic logic signed [WORD_W-1:0] clip_add(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      return s[WORD_W] ? WMIN : WMAX;
    end
    return s[WORD_W-1:0];
  endfunction

  // exact product, magnitude rounded half away from zero, then saturated
  function automatic logic signed [WORD_W-1:0] scale_by_h(input logic signed [WORD_W-1:0] h,
                                                          input logic signed [WORD_W-1:0] v);
    longint p;
    longint m;
    p = longint'(h) * longint'(v);
    m = (p < 0) ? -p : p;
    m = (m + 64'sd32768) >>> FRAC_W;
    if (p < 0) begin
      if (m > 64'sd2147483648) m = 64'sd2147483648;
      m = -m;
    end else if (m > 64'sd2147483647) begin
      m = 64'sd2147483647;
    end
    return m[WORD_W-1:0];
  endfunction

  // one integration step of the selected method
  function automatic void advance_point();
    logic signed [WORD_W-1:0] h, k1, k2, k3, k4, xh, xm, y, s;
    h  = {1'b0, rk_h};
    y  = pt_y;
    k1 = scale_by_h(h, clip_add(pt_x, pt_y));
    xh = clip_add(pt_x, h);
    if (rk_method == MTH_EULER) begin
      y = clip_add(y, k1);
    end else if (rk_method == MTH_HEUN) begin
      k2 = scale_by_h(h, clip_add(xh, clip_add(y, k1)));
      y  = clip_add(y, clip_add(k1, k2) >>> 1);
    end else begin
      xm = clip_add(pt_x, h >>> 1);
      k2 = scale_by_h(h, clip_add(xm, clip_add(y, k1 >>> 1)));
      k3 = scale_by_h(h, clip_add(xm, clip_add(y, k2 >>> 1)));
      k4 = scale_by_h(h, clip_add(xh, clip_add(y, k3)));
      s  = clip_add(clip_add(clip_add(k1, clip_add(k2, k2)), clip_add(k3, k3)), k4);
      y  = clip_add(y, s / 32'sd6);
    end
    pt_y = y;
    pt_x = xh;
    if (pt_steps != {STEP_W{1'b1}}) pt_steps++;
  endfunction

  // report caused by one word, then the state update
  function automatic report_t predict_report(input stim_word_t w);
    report_t r;
    if (w.command == CMD_LOAD) begin
      pt_x     = w.start_x;
      pt_y     = w.start_y;
      pt_steps = '0;
    end
    r.step_index = pt_steps;
    r.x_value    = pt_x;
    r.y_value    = pt_y;
    r.slope      = clip_add(pt_x, pt_y);
    r.done_res   = 1'b0;
    if (w.command == CMD_STEP) begin
      if (pt_x < rk_end_x) advance_point();
      else r.done_res = 1'b1;
    end
    return r;
  endfunction

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, 5)) : 0;
  endfunction

  // uniform value within +-span in Q16.16
  function automatic int q16_near(input int span);
    return int'($urandom_range(0, 2 * span * Q_ONE)) - span * Q_ONE;
  endfunction

  task automatic push_word(input cmd_t c, input logic signed [WORD_W-1:0] sx,
                           input logic signed [WORD_W-1:0] sy);
    stim_word_t w;
    w.command = c;
    w.start_x = sx;
    w.start_y = sy;
    cmd_q.push_back(w);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_METHOD: rk_method = data[MTH_W-1:0];
      REG_STEP:   rk_h      = data[H_W-1:0];
      REG_END:    rk_end_x  = data;
      default: ;
    endcase
  endtask

  // sender holds back until every report is in and the block has finished its step
  task automatic wait_drained();
    while (cmd_q.size() != 0 || tx_live || report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random register setting, unused upper data bits filled with noise
  task automatic pick_setting();
    logic [CFG_DATA_W-1:0] d;
    int                    sel;
    d      = $urandom;
    d[1:0] = 2'($urandom_range(0, 3));
    write_reg(REG_METHOD, d);
    d   = $urandom;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       d[H_W-1:0] = '0;
      1:       d[H_W-1:0] = 31'd1;
      2:       d[H_W-1:0] = {H_W{1'b1}};
      3:       ;
      default: d[H_W-1:0] = 31'($urandom_range(655, 49152));
    endcase
    write_reg(REG_STEP, d);
    sel = $urandom_range(0, 9);
    case (sel)
      0:       d = WMIN;
      1:       d = WMAX;
      2:       d = $urandom;
      default: d = q16_near(8);
    endcase
    write_reg(REG_END, d);
  endtask

  // mostly load-then-step runs with random content, some raw noise words
  task automatic queue_burst(input int n_items);
    int   cnt;
    int   runs;
    logic signed [WORD_W-1:0] sx, sy;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(cmd_t'($urandom_range(0, 1)), $urandom, $urandom);
        cnt++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          sx = $urandom;
          sy = $urandom;
        end else begin
          sx = q16_near(8);
          sy = q16_near(4);
        end
        push_word(CMD_LOAD, sx, sy);
        runs = $urandom_range(1, 16);
        repeat (runs) push_word(CMD_STEP, $urandom, $urandom);
        cnt += runs + 1;
      end
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

  // long receiver hold-off while the sender keeps offering words
  initial begin
    rx_block = 1'b0;
    wait (rx_hold_go == 1'b1);
    @(posedge clk);
    rx_block <= 1'b1;
    repeat (RX_HOLD_CYC) @(posedge clk);
    rx_block <= 1'b0;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        report_q.push_back(predict_report(tx_word));
        tx_live = 1'b0;
        tx_gap  = draw_gap();
      end
      if (!tx_live) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (cmd_q.size() != 0) begin
          tx_word = cmd_q.pop_front();
          tx_live = 1'b1;
        end
      end
      in_ch.valid   <= tx_live;
      in_ch.command <= tx_word.command;
      in_ch.start_x <= tx_word.start_x;
      in_ch.start_y <= tx_word.start_y;
    end
  end

  // result monitor and ready control
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.step_index = out_ch.step_index;
        got.x_value    = out_ch.x_value;
        got.y_value    = out_ch.y_value;
        got.slope      = out_ch.slope;
        got.done_res   = out_ch.done_res;
        if (report_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN) $display("unexpected report word: %p", got);
        end else begin
          want = report_q.pop_front();
          if (got.step_index !== want.step_index || got.x_value !== want.x_value ||
              got.y_value !== want.y_value || got.slope !== want.slope ||
              got.done_res !== want.done_res) begin
            fail_cnt++;
            if (fail_cnt <= MAX_SHOWN) begin
              $display("report mismatch: idx %0d/%0d x %0d/%0d y %0d/%0d slope %0d/%0d done %0b/%0b",
                       want.step_index, got.step_index, want.x_value, got.x_value,
                       want.y_value, got.y_value, want.slope, got.slope,
                       want.done_res, got.done_res);
            end
          end
        end
        rx_gap = draw_gap();
      end
      if (rx_block) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_METHOD;
    cfg_wdata     = '0;
    tx_word       = '0;
    rst_n         = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: run from the origin until x reaches end_x
    push_word(CMD_LOAD, 0, 0);
    repeat (6) push_word(CMD_STEP, 0, 0);
    // extremes: already past end_x, and saturating slopes
    push_word(CMD_LOAD, WMAX, WMIN);
    push_word(CMD_STEP, WMIN, WMAX);
    push_word(CMD_LOAD, WMIN, WMAX);
    push_word(CMD_STEP, WMAX, WMAX);
    push_word(CMD_LOAD, WMIN, WMIN);
    push_word(CMD_STEP, 0, 0);
    wait_drained();

    // first order, unit step
    write_reg(REG_METHOD, MTH_EULER);
    write_reg(REG_STEP, Q_ONE);
    write_reg(REG_END, 2 * Q_ONE);
    push_word(CMD_LOAD, -Q_ONE, 3 * Q_ONE);
    repeat (2) push_word(CMD_STEP, 0, 0);
    wait_drained();

    // second order
    write_reg(REG_METHOD, MTH_HEUN);
    push_word(CMD_LOAD, 0, Q_ONE);
    repeat (2) push_word(CMD_STEP, 0, 0);
    wait_drained();

    // unused selector value
    write_reg(REG_METHOD, MTH_SPARE);
    push_word(CMD_LOAD, 0, Q_ONE);
    push_word(CMD_STEP, 0, 0);
    wait_drained();

    // zero step size keeps x where it is
    write_reg(REG_STEP, 0);
    push_word(CMD_LOAD, -Q_ONE, 0);
    repeat (2) push_word(CMD_STEP, 0, 0);
    wait_drained();

    // lowest end_x: every step reports done
    write_reg(REG_END, WMIN);
    push_word(CMD_LOAD, WMIN, 0);
    push_word(CMD_STEP, 0, 0);
    wait_drained();

    // random phases, each under a new setting
    for (int ph = 0; ph < 8; ph++) begin
      pick_setting();
      idle_on = (ph != 5);
      if (ph == 3) rx_hold_go = 1'b1;
      queue_burst(230);
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: runge_kutta_stepper_x_plus_y_core.f
src/rkxy_pkg.sv
src/rkxy_in_if.sv
src/rkxy_out_if.sv
src/rkxy_ctrl.sv
src/rkxy_dp.sv
src/runge_kutta_stepper_x_plus_y_core.sv
bench/runge_kutta_stepper_x_plus_y_core_tb.sv
